[src/flux_revolution_splitter_top_macros.svh]
// Assertion macros shared by the flux revolution splitter RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst_n is low.
`ifndef FLUX_REVOLUTION_SPLITTER_TOP_MACROS_SVH
`define FLUX_REVOLUTION_SPLITTER_TOP_MACROS_SVH

// The expression holds at every clock edge.
`define FRS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define FRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/frs_pkg.sv]
// ----------------------------------------------------------------------------
// frs_pkg
// Types, codes and constants shared by the flux revolution splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

    localparam int unsigned DURATION_DEPTH_DEF = 16;
    localparam int unsigned INDEX_BITS_DEF     = 24;
    localparam int unsigned TICK_BITS_DEF      = 32;

    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned TICKS_W   = 32;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned OFFSET_W  = 24;
    localparam int unsigned NUM_W     = 5;
    localparam int unsigned CFG_W     = 5;

    localparam logic [CFG_W-1:0] MAX_OFFSETS_RESET = 5'd17;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_INTERVAL = 2'd1,
        OP_END      = 2'd2,
        OP_NONE     = 2'd3
    } frs_op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_START    = 2'd0,
        KIND_BOUNDARY = 2'd1,
        KIND_FINAL    = 2'd2
    } frs_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAD,
        S_LEAD_RD,
        S_BOUND,
        S_BOUND_RD,
        S_ADD
    } frs_state_t;

    typedef struct packed {
        frs_op_t             opcode;
        logic [TICKS_W-1:0]  duration_ticks;
        logic [TICKS_W-1:0]  interval_ticks;
    } frs_in_t;

    typedef struct packed {
        frs_kind_t           kind;
        logic [OFFSET_W-1:0] offset;
        logic [OFFSET_W-1:0] closed_length;
        logic [NUM_W-1:0]    revolution_number;
        logic                last;
    } frs_out_t;

    // Narrow a zero-extended interval index to the result field width.
    function automatic logic [OFFSET_W-1:0] index_field(input logic [31:0] value);
        return value[OFFSET_W-1:0];
    endfunction

    // Narrow a zero-extended offset count to the result field width.
    function automatic logic [NUM_W-1:0] count_field(input logic [31:0] value);
        return value[NUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/flux_revolution_splitter_top.sv]
// ----------------------------------------------------------------------------
// flux_revolution_splitter_top
// Splits a flux interval stream into disk revolutions against a duration table.
// ----------------------------------------------------------------------------
// Usage. Input beats carry an opcode: load one revolution duration into the
// table, one flux interval, end of stream, or nothing. Result beats carry a
// start offset, a revolution boundary, or the final length at end of stream,
// with last set on the final result that one input beat causes. Both channels
// use valid and stall; a beat moves when valid is high and stall is low.
// The max_offsets register is written through the cfg channel, which is
// always ready; write it only while the block has no work in flight.
// Loads, end beats and intervals that close no revolution are finished in
// the idle state that accepts them; no new beat is taken until the block is
// idle again. The first interval of a stream reads table entries in turn,
// skipping zero durations, until the first live entry or the end of the
// loaded table; with an offset limit of one it reads none. An interval that
// closes revolutions reads the next loaded duration for each boundary, but
// not on the one where the offset limit ends the search.
// A result appears on the output register the cycle after it is formed.
// Reset clears all stream state and sets max_offsets to 17; the table
// contents are not cleared and are only read below the loaded count.
// While the receiver stalls, the result beat holds and the block waits
// before forming another result, so no beat is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flux_revolution_splitter_top_macros.svh"

module flux_revolution_splitter_top #(
    parameter int unsigned DURATION_DEPTH = frs_pkg::DURATION_DEPTH_DEF,
    parameter int unsigned INDEX_BITS     = frs_pkg::INDEX_BITS_DEF,
    parameter int unsigned TICK_BITS      = frs_pkg::TICK_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output      logic                       cfg_ready,
    input  wire logic [frs_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire frs_pkg::frs_in_t           in_data,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      frs_pkg::frs_out_t          out_data
);

    import frs_pkg::*;

    // Pointer and loaded count must hold the depth itself.
    localparam int unsigned PTR_W  = $clog2(DURATION_DEPTH + 1);
    localparam int unsigned ADDR_W = (DURATION_DEPTH > 1) ? $clog2(DURATION_DEPTH) : 1;
    // Offsets reported never exceed the depth plus one.
    localparam int unsigned CNT_W  = $clog2(DURATION_DEPTH + 2);
    localparam int unsigned LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    // The accumulator holds a duration overhang plus one interval.
    localparam int unsigned EL_W   = TICK_BITS + 2;

    localparam logic [PTR_W-1:0] DEPTH_P   = PTR_W'(DURATION_DEPTH);
    localparam logic [LIM_W-1:0] LIMIT_MAX = LIM_W'(DURATION_DEPTH + 1);

    frs_state_t              state_reg, state_next;
    logic [CFG_W-1:0]        max_offsets_reg, max_offsets_next;
    logic [PTR_W-1:0]        loaded_reg, loaded_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [EL_W-1:0]         elapsed_reg, elapsed_next;
    logic [INDEX_BITS-1:0]   seen_reg, seen_next;
    logic [CNT_W-1:0]        offsets_reg, offsets_next;
    logic [INDEX_BITS-1:0]   prev_reg, prev_next;
    logic                    pending_reg, pending_next;
    logic                    finished_reg, finished_next;
    logic [TICK_BITS-1:0]    cur_dur_reg, cur_dur_next;
    logic [TICK_BITS-1:0]    iv_reg, iv_next;
    logic                    out_valid_reg, out_valid_next;
    frs_out_t                out_data_reg, out_data_next;

    logic                    accept;
    logic                    out_free;
    logic                    emit;
    frs_out_t                res;
    logic [LIM_W-1:0]        max_ext;
    logic [LIM_W-1:0]        limit;
    logic [LIM_W-1:0]        offsets_inc;
    logic [PTR_W-1:0]        ptr_inc;
    logic [EL_W-1:0]         el_sum;
    logic [EL_W-1:0]         el_sub;
    logic [INDEX_BITS-1:0]   seen_sat;
    logic [INDEX_BITS-1:0]   run_len;
    logic                    search_live;

    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic                    ram_rd_en;
    logic [ADDR_W-1:0]       ram_rd_addr;
    logic [TICK_BITS-1:0]    ram_rd_data;

    frs_ram #(
        .WIDTH (TICK_BITS),
        .DEPTH (DURATION_DEPTH)
    ) u_duration_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_data.duration_ticks[TICK_BITS-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // A result slot is free when the output register is empty or drains now.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Effective offset limit: zero acts as one, and the table depth plus one caps it.
    assign max_ext = LIM_W'(max_offsets_reg);
    assign limit   = (max_ext == '0) ? LIM_W'(1)
                   : ((max_ext > LIMIT_MAX) ? LIMIT_MAX : max_ext);

    assign offsets_inc = LIM_W'(offsets_reg) + LIM_W'(1);
    assign ptr_inc     = ptr_reg + PTR_W'(1);
    assign el_sum      = elapsed_reg + EL_W'(iv_reg);
    assign el_sub      = elapsed_reg - EL_W'(cur_dur_reg);
    assign seen_sat    = (seen_reg == '1) ? seen_reg : (seen_reg + INDEX_BITS'(1));
    assign run_len     = seen_reg - prev_reg;

    // Idle between items with a search still running.
    assign search_live = (state_reg == S_IDLE) && (offsets_reg != '0) && !finished_reg;

    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        ptr_next      = ptr_reg;
        elapsed_next  = elapsed_reg;
        seen_next     = seen_reg;
        offsets_next  = offsets_reg;
        prev_next     = prev_reg;
        pending_next  = pending_reg;
        finished_next = finished_reg;
        cur_dur_next  = cur_dur_reg;
        iv_next       = iv_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = loaded_reg[ADDR_W-1:0];
        ram_rd_en     = 1'b0;
        ram_rd_addr   = ptr_reg[ADDR_W-1:0];
        emit          = 1'b0;
        res           = '{kind: KIND_START, offset: '0, closed_length: '0,
                          revolution_number: '0, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.opcode)
                        OP_LOAD:
                        begin
                            if (loaded_reg < DEPTH_P)
                            begin
                                ram_wr_en   = 1'b1;
                                loaded_next = loaded_reg + PTR_W'(1);
                            end
                        end
                        OP_INTERVAL:
                        begin
                            iv_next = in_data.interval_ticks[TICK_BITS-1:0];
                            if (offsets_reg == '0)
                            begin
                                // First interval of the stream reports offset zero.
                                emit                  = 1'b1;
                                res.kind              = KIND_START;
                                res.revolution_number = count_field(32'd1);
                                offsets_next          = CNT_W'(1);
                                prev_next             = '0;
                                if (limit == LIM_W'(1))
                                begin
                                    finished_next = 1'b1;
                                    pending_next  = 1'b0;
                                    seen_next     = seen_sat;
                                end
                                else
                                begin
                                    state_next = S_LEAD;
                                end
                            end
                            else if (pending_reg)
                            begin
                                state_next = S_BOUND;
                            end
                            else
                            begin
                                if (!finished_reg)
                                begin
                                    elapsed_next = elapsed_reg
                                                 + EL_W'(in_data.interval_ticks[TICK_BITS-1:0]);
                                    pending_next = (elapsed_next >= EL_W'(cur_dur_reg));
                                end
                                seen_next = seen_sat;
                            end
                        end
                        OP_END:
                        begin
                            if (offsets_reg != '0)
                            begin
                                emit                  = 1'b1;
                                res.kind              = KIND_FINAL;
                                res.offset            = index_field(32'(prev_reg));
                                res.closed_length     = index_field(32'(run_len));
                                res.revolution_number = count_field(32'(offsets_reg));
                            end
                            loaded_next   = '0;
                            ptr_next      = '0;
                            elapsed_next  = '0;
                            seen_next     = '0;
                            offsets_next  = '0;
                            prev_next     = '0;
                            pending_next  = 1'b0;
                            finished_next = 1'b0;
                        end
                        OP_NONE:
                        begin
                        end
                    endcase
                end
            end

            // Skip leading zero durations, one table entry per read.
            S_LEAD:
            begin
                if (ptr_reg >= loaded_reg)
                begin
                    finished_next = 1'b1;
                    state_next    = S_ADD;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg[ADDR_W-1:0];
                    state_next  = S_LEAD_RD;
                end
            end

            S_LEAD_RD:
            begin
                if (ram_rd_data == '0)
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_LEAD;
                end
                else
                begin
                    cur_dur_next = ram_rd_data;
                    state_next   = S_ADD;
                end
            end

            // Close one revolution; fetch the next duration unless the limit ends it.
            S_BOUND:
            begin
                if (offsets_inc >= limit)
                begin
                    if (out_free)
                    begin
                        emit                  = 1'b1;
                        res.kind              = KIND_BOUNDARY;
                        res.offset            = index_field(32'(seen_reg));
                        res.closed_length     = index_field(32'(run_len));
                        res.revolution_number = count_field(32'(offsets_inc));
                        offsets_next          = CNT_W'(offsets_inc);
                        prev_next             = seen_reg;
                        elapsed_next          = el_sub;
                        ptr_next              = ptr_inc;
                        finished_next         = 1'b1;
                        pending_next          = 1'b0;
                        state_next            = S_ADD;
                    end
                end
                else
                begin
                    ram_rd_en   = (ptr_inc < loaded_reg);
                    ram_rd_addr = ptr_inc[ADDR_W-1:0];
                    state_next  = S_BOUND_RD;
                end
            end

            S_BOUND_RD:
            begin
                if (out_free)
                begin
                    offsets_next = CNT_W'(offsets_inc);
                    prev_next    = seen_reg;
                    elapsed_next = el_sub;
                    ptr_next     = ptr_inc;
                    if ((ptr_inc >= loaded_reg) || (ram_rd_data == '0))
                    begin
                        finished_next = 1'b1;
                        pending_next  = 1'b0;
                    end
                    else
                    begin
                        cur_dur_next = ram_rd_data;
                        pending_next = (el_sub >= EL_W'(ram_rd_data));
                    end
                    emit                  = 1'b1;
                    res.kind              = KIND_BOUNDARY;
                    res.offset            = index_field(32'(seen_reg));
                    res.closed_length     = index_field(32'(run_len));
                    res.revolution_number = count_field(32'(offsets_inc));
                    res.last              = !pending_next;
                    state_next            = pending_next ? S_BOUND : S_ADD;
                end
            end

            // Fold the interval into the accumulator unless the search has finished, and count it.
            S_ADD:
            begin
                if (!finished_reg)
                begin
                    elapsed_next = el_sum;
                    pending_next = (el_sum >= EL_W'(cur_dur_reg));
                end
                else
                begin
                    pending_next = 1'b0;
                end
                seen_next  = seen_sat;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        max_offsets_next = cfg_valid ? cfg_data : max_offsets_reg;
        out_data_next    = emit ? res : out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_offsets_reg <= MAX_OFFSETS_RESET;
            loaded_reg      <= '0;
            ptr_reg         <= '0;
            elapsed_reg     <= '0;
            seen_reg        <= '0;
            offsets_reg     <= '0;
            prev_reg        <= '0;
            pending_reg     <= 1'b0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_offsets_reg <= max_offsets_next;
            loaded_reg      <= loaded_next;
            ptr_reg         <= ptr_next;
            elapsed_reg     <= elapsed_next;
            seen_reg        <= seen_next;
            offsets_reg     <= offsets_next;
            prev_reg        <= prev_next;
            pending_reg     <= pending_next;
            finished_reg    <= finished_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_dur_reg  <= cur_dur_next;
        iv_reg       <= iv_next;
        out_data_reg <= out_data_next;
    end

    // A boundary can only be waiting while the search is still running.
    `FRS_ASSERT_ALWAYS(a_pending_live, !(pending_reg && finished_reg), "boundary pending after search end")
    // Between items a running search always points at a loaded table entry.
    `FRS_ASSERT_ALWAYS(a_ptr_loaded, !search_live || (ptr_reg < loaded_reg), "search past loaded table")
    // A result without last must be followed by more work on the same item.
    `FRS_ASSERT_NEXT(a_more_follow, emit && !res.last, state_reg != S_IDLE, "item ended early")

endmodule

`default_nettype wire

[src/frs_ram.sv]
// ----------------------------------------------------------------------------
// frs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[test/flux_revolution_splitter_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_revolution_splitter_top_test
// Self-checking bench for the flux revolution splitter. A queue-fed driver
// sends load, interval, end and empty beats; a clocked monitor checks every
// result beat against a local revolution-splitting predictor. Both sides
// insert random gaps. The max_offsets register is reprogrammed between
// phases, only while the block is idle.
// ----------------------------------------------------------------------------

module flux_revolution_splitter_top_test;

    import frs_pkg::*;

    // An interval whose first use scans the whole table reads every entry
    // in turn. Wait well past that before touching the register
    // or ending the run.
    localparam int SETTLE_CYCLES = 64;

    // The longest correct stretch without any accepted beat is one settle
    // pause plus a full table scan. The limit
    // leaves a wide margin over that, even with long random stalls.
    localparam int STUCK_LIMIT = 4000;

    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 32;
    localparam int unsigned DEPTH = DURATION_DEPTH_DEF;

    logic clk;
    logic rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    frs_in_t           in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    frs_out_t          out_data;

    flux_revolution_splitter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Beats waiting to be sent, and result beats the predictor has formed
    // but the block has not delivered yet.
    frs_in_t  beats_to_send [$];
    frs_out_t marks_due [$];

    int unsigned queued_items = 0;
    int unsigned fail_count = 0;
    int unsigned send_gap_pct = 22;
    int unsigned recv_stall_pct = 22;
    int unsigned stuck_cycles = 0;

    // ------------------------------------------------------------------
    // Predictor state: the duration table, the search position and the
    // running interval count of the current stream.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    max_offsets_reg = MAX_OFFSETS_RESET;
    logic [TICKS_W-1:0]  dur_table [DEPTH];
    int unsigned         dur_count = 0;
    int unsigned         dur_index = 0;
    logic [63:0]         elapsed = '0;
    logic [OFFSET_W-1:0] flux_count = '0;
    int unsigned         offsets_count = 0;
    logic [OFFSET_W-1:0] last_offset = '0;
    bit                  boundary_due = 1'b0;
    bit                  search_done = 1'b0;

    // A register value of zero still lets the start offset through, and
    // no more offsets exist than table entries plus the start.
    function automatic int unsigned offsets_allowed();
        int unsigned m;
        m = max_offsets_reg;
        if (m == 0)
            m = 1;
        if (m > DEPTH + 1)
            m = DEPTH + 1;
        return m;
    endfunction

    function automatic logic [63:0] live_duration();
        if (dur_index < dur_count && dur_index < DEPTH)
            return {32'd0, dur_table[dur_index]};
        return '0;
    endfunction

    // Move to the next usable duration. Only the first pick of a stream
    // skips zero entries; any later zero, running off the table or hitting
    // the offset limit stops the search.
    function automatic void pick_duration(input bit leading);
        if (offsets_count >= offsets_allowed())
        begin
            search_done = 1'b1;
            return;
        end
        while (leading && dur_index < dur_count && dur_table[dur_index] == '0)
            dur_index++;
        if (dur_index >= dur_count || live_duration() == '0)
            search_done = 1'b1;
    endfunction

    function automatic void clear_stream();
        dur_count = 0;
        dur_index = 0;
        elapsed = '0;
        flux_count = '0;
        offsets_count = 0;
        last_offset = '0;
        boundary_due = 1'b0;
        search_done = 1'b0;
    endfunction

    function automatic void add_mark(input frs_kind_t kind, input logic [OFFSET_W-1:0] at,
                                     input logic [OFFSET_W-1:0] span,
                                     input int unsigned number);
        frs_out_t r;
        r.kind = kind;
        r.offset = at;
        r.closed_length = span;
        r.revolution_number = number[NUM_W-1:0];
        r.last = 1'b0;
        marks_due.push_back(r);
    endfunction

    // Work out the result beats that one accepted input beat causes.
    function automatic void split_flux(input frs_in_t beat);
        logic [OFFSET_W-1:0] at_index;
        int unsigned first_new;
        frs_out_t r;
        first_new = marks_due.size();
        case (beat.opcode)
            OP_LOAD:
            begin
                // A full table silently drops further loads.
                if (dur_count < DEPTH)
                begin
                    dur_table[dur_count] = beat.duration_ticks;
                    dur_count++;
                end
            end
            OP_END:
            begin
                // A stream that never saw an interval ends without a result.
                if (offsets_count != 0)
                    add_mark(KIND_FINAL, last_offset, flux_count - last_offset,
                             offsets_count);
                clear_stream();
            end
            OP_INTERVAL:
            begin
                at_index = flux_count;
                if (offsets_count == 0)
                begin
                    offsets_count = 1;
                    last_offset = '0;
                    add_mark(KIND_START, '0, '0, 1);
                    pick_duration(1'b1);
                end
                // A boundary found on the previous interval is only reported
                // now; a large overhang can close several revolutions at once.
                while (!search_done && boundary_due)
                begin
                    offsets_count++;
                    add_mark(KIND_BOUNDARY, at_index, at_index - last_offset,
                             offsets_count);
                    last_offset = at_index;
                    elapsed = elapsed - live_duration();
                    dur_index++;
                    pick_duration(1'b0);
                    boundary_due = !search_done && elapsed >= live_duration();
                end
                if (search_done)
                begin
                    boundary_due = 1'b0;
                end
                else
                begin
                    elapsed = elapsed + {32'd0, beat.interval_ticks};
                    boundary_due = elapsed >= live_duration();
                end
                if (at_index != '1)
                    flux_count = at_index + 1'b1;
            end
            default:
            begin
                // Empty beats are ignored.
            end
        endcase
        if (marks_due.size() > first_new)
        begin
            r = marks_due.pop_back();
            r.last = 1'b1;
            marks_due.push_back(r);
        end
    endfunction

    // Compare one delivered result beat with the oldest expectation.
    function automatic void check_mark(input frs_out_t got);
        frs_out_t want;
        if (marks_due.size() == 0)
        begin
            $error("unexpected result beat: kind %0d offset %0d length %0d number %0d",
                   got.kind, got.offset, got.closed_length, got.revolution_number);
            fail_count++;
            return;
        end
        want = marks_due.pop_front();
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            fail_count++;
        end
        if (got.offset !== want.offset)
        begin
            $error("offset: expected %0d, actual %0d", want.offset, got.offset);
            fail_count++;
        end
        if (got.closed_length !== want.closed_length)
        begin
            $error("closed_length: expected %0d, actual %0d",
                   want.closed_length, got.closed_length);
            fail_count++;
        end
        if (got.revolution_number !== want.revolution_number)
        begin
            $error("revolution_number: expected %0d, actual %0d",
                   want.revolution_number, got.revolution_number);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the next queued beat whenever the current one has
    // moved or none is up, skipping cycles at random. A stalled beat is
    // held unchanged. The prediction is made at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                split_flux(in_data);
            if (!in_valid || !in_stall)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= beats_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat and stalls at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_mark(out_data);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: any beat moving on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one beat. Unused fields carry what the caller passes; the random
    // streams give them random data so every bit of every field toggles.
    task automatic push_beat(input frs_op_t op, input logic [TICKS_W-1:0] dur,
                             input logic [TICKS_W-1:0] gap);
        frs_in_t b;
        b.opcode = op;
        b.duration_ticks = dur;
        b.interval_ticks = gap;
        beats_to_send.push_back(b);
        if (op != OP_NONE)
            queued_items++;
    endtask

    // One random stream: a duration table, a run of intervals with the
    // odd late load or empty beat mixed in, and usually an end beat.
    // Durations and intervals share a scale so that revolutions close
    // every few intervals; now and then a huge interval closes several.
    task automatic queue_stream();
        logic [TICKS_W-1:0] span;
        logic [TICKS_W-1:0] dur;
        logic [TICKS_W-1:0] gap;
        int unsigned n_loads;
        int unsigned n_flux;
        span = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : (32'd1 << $urandom_range(12, 4));
        case ($urandom_range(19))
            0:       n_loads = 0;
            1, 2:    n_loads = $urandom_range(18, 14);
            default: n_loads = $urandom_range(6, 1);
        endcase
        for (int k = 0; k < n_loads; k++)
        begin
            if ((k < 2 && $urandom_range(5) == 0) || $urandom_range(29) == 0)
                dur = '0;
            else
                dur = $urandom_range(span, span >> 1);
            push_beat(OP_LOAD, dur, $urandom);
        end
        n_flux = ($urandom_range(19) == 0) ? 0 : $urandom_range(40, 2);
        for (int k = 0; k < n_flux; k++)
        begin
            if ($urandom_range(15) == 0)
                push_beat(OP_LOAD, $urandom_range(span, span >> 1), $urandom);
            if ($urandom_range(31) == 0)
                push_beat(OP_NONE, $urandom, $urandom);
            gap = ($urandom_range(11) == 0) ? $urandom : $urandom_range(span / 6);
            push_beat(OP_INTERVAL, $urandom, gap);
        end
        if ($urandom_range(9) != 0)
            push_beat(OP_END, $urandom, $urandom);
    endtask

    // Hold the sender until every queued beat has gone, every expected
    // result has come back, and the block has had time to finish any
    // beat that produces no result.
    task automatic wait_quiet();
        while (beats_to_send.size() != 0 || in_valid || marks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_offsets(input logic [CFG_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_offsets_reg = value;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] cfg_plan [PHASES];
        cfg_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd0, 5'd16, 5'd0};
        cfg_plan[5] = $urandom_range(31);
        cfg_plan[7] = $urandom_range(31);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset value of the register.
        // An end beat on an empty stream, then an empty beat.
        push_beat(OP_END, $urandom, $urandom);
        push_beat(OP_NONE, $urandom, $urandom);
        // Intervals with no table: the start offset comes out and the
        // search stops at once; the largest interval is only counted.
        push_beat(OP_INTERVAL, $urandom, 32'd7);
        push_beat(OP_INTERVAL, 32'd0, 32'hFFFF_FFFF);
        push_beat(OP_END, $urandom, $urandom);
        // Leading zero durations are skipped, the largest duration is
        // reached by the largest interval, and a zero loaded after the
        // intervals began ends the search when it comes up.
        push_beat(OP_LOAD, 32'd0, 32'hFFFF_FFFF);
        push_beat(OP_LOAD, 32'd0, 32'd0);
        push_beat(OP_LOAD, 32'd10, $urandom);
        push_beat(OP_LOAD, 32'hFFFF_FFFF, 32'd0);
        push_beat(OP_INTERVAL, 32'hFFFF_FFFF, 32'd0);
        push_beat(OP_INTERVAL, $urandom, 32'd12);
        push_beat(OP_INTERVAL, $urandom, 32'hFFFF_FFFF);
        push_beat(OP_LOAD, 32'd0, $urandom);
        push_beat(OP_INTERVAL, $urandom, 32'd1);
        push_beat(OP_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // One long interval carries enough overhang to close every
        // remaining revolution on the following beat.
        push_beat(OP_LOAD, 32'd5, $urandom);
        push_beat(OP_LOAD, 32'd5, $urandom);
        push_beat(OP_LOAD, 32'd5, $urandom);
        push_beat(OP_INTERVAL, $urandom, 32'd20);
        push_beat(OP_INTERVAL, $urandom, 32'd1);
        push_beat(OP_INTERVAL, $urandom, 32'd9);
        push_beat(OP_END, $urandom, $urandom);
        // The stream ends while a boundary is still pending.
        push_beat(OP_LOAD, 32'd6, $urandom);
        push_beat(OP_INTERVAL, $urandom, 32'd6);
        push_beat(OP_END, $urandom, $urandom);
        wait_quiet();

        // Random phases, each under its own register setting. One phase
        // runs with no gaps and no stalls at all.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_max_offsets(cfg_plan[phase]);
            send_gap_pct = (phase == 3) ? 0 : 22;
            recv_stall_pct = (phase == 3) ? 0 : 22;
            queued_items = 0;
            while (queued_items < PHASE_ITEMS)
                queue_stream();
            wait_quiet();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
